// ===== hw/rtl/tsrb_pkg.sv =====
`default_nettype none
package tsrb_pkg;

  localparam int ROW_W  = 12;
  localparam int CTR_W  = 12;
  localparam int HALF_W = 11;
  localparam int SOFT_W = 7;
  localparam int PIX_W  = 8;
  localparam int CFG_W  = 12;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_ROWS_DEF = 4096;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ROW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFTNESS    = 2'd2;

  localparam int ARG_W  = 14;
  localparam int RCP_W  = 17;
  localparam int XPR_W  = 31;
  localparam int MAG_W  = 30;
  localparam int TQ_W   = 17;
  localparam int T_W    = 18;
  localparam int D_W    = 19;
  localparam int W_W    = 8;
  localparam int V_W    = 17;

  localparam int TANH_ENTRIES = 256;
  localparam int TANH_IDX_W   = 8;
  localparam int TANH_LSB     = 10;
  localparam int RCP_ENTRIES  = 128;

  localparam logic [63:0] Q24_ONE      = 64'd16777216;
  localparam logic [63:0] EXP_STEP_Q24 = 64'd17309782;
  localparam logic [TQ_W-1:0] Q16_ONE  = 17'd65536;
  localparam logic [RCP_W-1:0] RCP_RESET = 17'd9362;

  localparam logic [V_W-1:0] ROUND_HALF   = 17'd127;
  localparam logic [V_W-1:0] DIV255_MUL   = 17'd32897;
  localparam int             DIV255_SHIFT = 23;
  localparam logic [W_W-1:0] W_FULL       = 8'd255;

  typedef logic [TQ_W-1:0]  tanh_rom_t  [TANH_ENTRIES];
  typedef logic [RCP_W-1:0] recip_rom_t [RCP_ENTRIES];

  typedef struct packed {
    logic [PIX_W-1:0] orig_b;
    logic [PIX_W-1:0] orig_g;
    logic [PIX_W-1:0] orig_r;
    logic [PIX_W-1:0] blur_b;
    logic [PIX_W-1:0] blur_g;
    logic [PIX_W-1:0] blur_r;
  } pix_t;

  // shift-subtract quotient, evaluated only while building the tables
  function automatic logic [63:0] const_udiv(input logic [63:0] n, input logic [63:0] dv);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, dv}) begin
        rem    = rem - {1'b0, dv};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t   rom;
    logic [63:0] p;
    logic [63:0] num;
    logic [63:0] den;
    p = Q24_ONE;
    for (int k = 0; k < TANH_ENTRIES; k++) begin
      num    = (p - Q24_ONE) << 16;
      den    = p + Q24_ONE;
      rom[k] = TQ_W'(const_udiv(num + (den >> 1), den));
      p      = (p * EXP_STEP_Q24 + (Q24_ONE >> 1)) >> 24;
    end
    return rom;
  endfunction

  function automatic recip_rom_t build_recip_rom();
    recip_rom_t rom;
    rom[0] = RCP_W'(65536);
    for (int s = 1; s < RCP_ENTRIES; s++) begin
      rom[s] = RCP_W'(const_udiv(64'd65536, 64'(s)));
    end
    return rom;
  endfunction

  localparam tanh_rom_t  TANH_ROM  = build_tanh_rom();
  localparam recip_rom_t RECIP_ROM = build_recip_rom();

endpackage
`default_nettype wire

// ===== hw/rtl/tsrb_if.sv =====
`default_nettype none
interface tsrb_in_if;
  logic                      valid;
  logic                      ready;
  logic [tsrb_pkg::ROW_W-1:0] row;
  logic [tsrb_pkg::PIX_W-1:0] orig_b;
  logic [tsrb_pkg::PIX_W-1:0] orig_g;
  logic [tsrb_pkg::PIX_W-1:0] orig_r;
  logic [tsrb_pkg::PIX_W-1:0] blur_b;
  logic [tsrb_pkg::PIX_W-1:0] blur_g;
  logic [tsrb_pkg::PIX_W-1:0] blur_r;

  modport source (output valid, row, orig_b, orig_g, orig_r, blur_b, blur_g, blur_r,
                  input ready);
  modport sink   (input valid, row, orig_b, orig_g, orig_r, blur_b, blur_g, blur_r,
                  output ready);
endinterface

interface tsrb_out_if;
  logic                      valid;
  logic                      ready;
  logic [tsrb_pkg::PIX_W-1:0] out_b;
  logic [tsrb_pkg::PIX_W-1:0] out_g;
  logic [tsrb_pkg::PIX_W-1:0] out_r;

  modport source (output valid, out_b, out_g, out_r, input ready);
  modport sink   (input valid, out_b, out_g, out_r, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tilt_shift_row_blend.sv =====
// Tilt-shift row blend.
// Mixes an original BGR pixel with its blurred copy; the original's weight
// depends only on the pixel row and follows a tanh band around center_row.
// Channels: in_s takes one beat per pixel (row, original and blurred BGR),
// out_m returns one beat per pixel (blended BGR), both valid/ready.
// Configuration: cfg_we/cfg_idx/cfg_data write center_row (0), half_height (1)
// and softness (2); other indexes are dropped. Write only while idle.
// Throughput: one pixel per cycle unless out_m stalls; seven register stages
// (argument, scale multiply, tanh lookup, weight, channel multiply, divide by
// 255, sum and saturate) advance together.
// Reset: rst_n synchronous, low active; clears the pipeline valids and loads
// register defaults (center 0, half height 0, softness 7).
// Stall: when out_m is stalled with a result waiting, the whole pipeline
// holds and in_s.ready drops; nothing is lost or repeated.
`default_nettype none
module tilt_shift_row_blend #(
  parameter int MAX_ROWS = tsrb_pkg::MAX_ROWS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [tsrb_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [tsrb_pkg::CFG_W-1:0]     cfg_data,
  tsrb_in_if.sink                             in_s,
  tsrb_out_if.source                          out_m
);
  import tsrb_pkg::*;

  localparam int NSTG = 7;
  localparam int ROW_LIM = (MAX_ROWS - 1 > 4095) ? 4095 : MAX_ROWS - 1;

  logic [CTR_W-1:0]  center_r;
  logic [HALF_W-1:0] half_r;
  logic [RCP_W-1:0]  recip_r;
  logic [NSTG-1:0]   v_r;
  logic              en;

  logic [ROW_W-1:0]        row_c;
  logic signed [ARG_W-1:0] a_nxt, b_nxt, a_r, b_r;
  pix_t                    pix_in, pix1_r, pix2_r, pix3_r, pix4_r;

  logic signed [2*T_W-1:0]   xa_full, xb_full;
  logic signed [XPR_W-1:0]   xa_r, xb_r;
  logic signed [T_W-1:0]     ta_nxt, tb_nxt, ta_r, tb_r;
  logic signed [D_W-1:0]     d;
  logic [T_W-1:0]            dm;
  logic [T_W+W_W-1:0]        dw;
  logic [W_W-1:0]            w_nxt, w_r, wi;
  logic [V_W-1:0]            vo_nxt [3];
  logic [V_W-1:0]            vb_nxt [3];
  logic [V_W-1:0]            vo_r   [3];
  logic [V_W-1:0]            vb_r   [3];
  logic [W_W-1:0]            qo_nxt [3];
  logic [W_W-1:0]            qb_nxt [3];
  logic [W_W-1:0]            qo_r   [3];
  logic [W_W-1:0]            qb_r   [3];
  logic [PIX_W-1:0]          res_nxt [3];
  logic [PIX_W-1:0]          res_r   [3];
  logic [PIX_W-1:0]          po [3];
  logic [PIX_W-1:0]          pb [3];

  function automatic logic signed [T_W-1:0] tanh_q16(input logic signed [XPR_W-1:0] x);
    logic [MAG_W-1:0] mag;
    logic [TQ_W-1:0]  t;
    mag = x[XPR_W-1] ? MAG_W'(-x) : MAG_W'(x);
    if (|mag[MAG_W-1:TANH_LSB+TANH_IDX_W]) begin
      t = Q16_ONE;
    end else begin
      t = TANH_ROM[mag[TANH_LSB+TANH_IDX_W-1:TANH_LSB]];
    end
    return x[XPR_W-1] ? -$signed({1'b0, t}) : $signed({1'b0, t});
  endfunction

  function automatic logic [W_W-1:0] div255(input logic [V_W-1:0] v);
    logic [2*V_W-1:0] p;
    p = v * DIV255_MUL;
    return p[DIV255_SHIFT+W_W-1:DIV255_SHIFT];
  endfunction

  assign en        = out_m.ready || !v_r[NSTG-1];
  assign in_s.ready = en;
  assign out_m.valid = v_r[NSTG-1];
  assign out_m.out_b = res_r[0];
  assign out_m.out_g = res_r[1];
  assign out_m.out_r = res_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= '0;
      half_r   <= '0;
      recip_r  <= RCP_RESET;
      v_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_CENTER_ROW:  center_r <= cfg_data[CTR_W-1:0];
          CFG_HALF_HEIGHT: half_r   <= cfg_data[HALF_W-1:0];
          CFG_SOFTNESS:    recip_r  <= RECIP_ROM[cfg_data[SOFT_W-1:0]];
          default:         ;
        endcase
      end
      if (en) begin
        v_r <= {v_r[NSTG-2:0], in_s.valid};
      end
    end
  end

  always_comb begin
    row_c = (32'(in_s.row) > ROW_LIM) ? ROW_W'(ROW_LIM) : in_s.row;
    a_nxt = $signed({2'b00, row_c}) - $signed({2'b00, center_r})
          + $signed({3'b000, half_r});
    b_nxt = $signed({2'b00, row_c}) - $signed({2'b00, center_r})
          - $signed({3'b000, half_r});
    pix_in = '{orig_b: in_s.orig_b, orig_g: in_s.orig_g, orig_r: in_s.orig_r,
               blur_b: in_s.blur_b, blur_g: in_s.blur_g, blur_r: in_s.blur_r};

    xa_full = T_W'(a_r) * $signed({1'b0, recip_r});
    xb_full = T_W'(b_r) * $signed({1'b0, recip_r});

    ta_nxt = tanh_q16(xa_r);
    tb_nxt = tanh_q16(xb_r);

    d     = D_W'(ta_r) - D_W'(tb_r);
    dm    = d[D_W-1] ? '0 : d[T_W-1:0];
    dw    = (T_W+W_W)'(dm) * (T_W+W_W)'(W_FULL);
    w_nxt = (|dw[T_W+W_W-1:TQ_W+W_W]) ? W_FULL : dw[TQ_W+W_W-1:TQ_W];

    wi    = W_FULL - w_r;
    po[0] = pix4_r.orig_b;
    po[1] = pix4_r.orig_g;
    po[2] = pix4_r.orig_r;
    pb[0] = pix4_r.blur_b;
    pb[1] = pix4_r.blur_g;
    pb[2] = pix4_r.blur_r;
    for (int c = 0; c < 3; c++) begin
      vo_nxt[c]  = V_W'(po[c]) * V_W'(w_r) + ROUND_HALF;
      vb_nxt[c]  = V_W'(pb[c]) * V_W'(wi) + ROUND_HALF;
      qo_nxt[c]  = div255(vo_r[c]);
      qb_nxt[c]  = div255(vb_r[c]);
      res_nxt[c] = ((9'(qo_r[c]) + 9'(qb_r[c])) > 9'(W_FULL))
                 ? W_FULL : qo_r[c] + qb_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      pix1_r <= pix_in;
      xa_r   <= xa_full[XPR_W-1:0];
      xb_r   <= xb_full[XPR_W-1:0];
      pix2_r <= pix1_r;
      ta_r   <= ta_nxt;
      tb_r   <= tb_nxt;
      pix3_r <= pix2_r;
      w_r    <= w_nxt;
      pix4_r <= pix3_r;
      vo_r   <= vo_nxt;
      vb_r   <= vb_nxt;
      qo_r   <= qo_nxt;
      qb_r   <= qb_nxt;
      res_r  <= res_nxt;
    end
  end

  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_m.valid && !out_m.ready |-> !in_s.ready)
    else $error("pipeline accepts while output is stalled");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_s.valid && in_s.ready |=> v_r[0])
    else $error("accepted beat missing from first stage");

  a_recip_range: assert property (@(posedge clk) disable iff (!rst_n)
    recip_r != '0 && recip_r <= Q16_ONE)
    else $error("reciprocal out of range");

  a_flat_weight: assert property (@(posedge clk) disable iff (!rst_n)
    en && v_r[2] && ta_r == tb_r |=> w_r == '0)
    else $error("equal tanh values gave nonzero weight");

endmodule
`default_nettype wire

// ===== dv/tilt_shift_row_blend_tb.sv =====
module tilt_shift_row_blend_tb;
  import tsrb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int N_PHASES  = 10;
  localparam int PHASE_PIX = 170;
  localparam int LAT       = 7;

  typedef struct packed {
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] r;
  } px_t;

  typedef enum logic {STIM_PIX, STIM_REG} stim_kind_e;

  typedef struct {
    stim_kind_e             kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_W-1:0]       data;
    logic [ROW_W-1:0]       row;
    pix_t                   pix;
    bit                     typed;
    px_t                    want;
  } stim_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  tsrb_in_if  in_if ();
  tsrb_out_if out_if ();

  tilt_shift_row_blend dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_s     (in_if),
    .out_m    (out_if)
  );

  longint           tanh_lut [TANH_ENTRIES];
  logic [CTR_W-1:0]  center_reg;
  logic [HALF_W-1:0] half_reg;
  logic [SOFT_W-1:0] soft_reg;
  px_t              blend_q [$];
  stim_t            dir_tab [$];
  int               errors;
  bit               idle_on;
  int               stall_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint tanh_at(longint x);
    longint m;
    longint t;
    m = (x < 0) ? -x : x;
    t = ((m >> 10) >= TANH_ENTRIES) ? 64'sd65536 : tanh_lut[m >> 10];
    return (x < 0) ? -t : t;
  endfunction

  function automatic logic [PIX_W-1:0] mix(int unsigned o, int unsigned bl, int unsigned w);
    int unsigned s;
    s = (o * w + 127) / 255 + (bl * (255 - w) + 127) / 255;
    return (s > 255) ? 8'd255 : s[PIX_W-1:0];
  endfunction

  function automatic px_t predict_blend(logic [ROW_W-1:0] row, pix_t p);
    longint a;
    longint b;
    longint recip;
    longint d;
    longint w;
    px_t    res;
    recip = 65536 / ((soft_reg == 0) ? 1 : longint'(soft_reg));
    a = longint'(row) - longint'(center_reg) + longint'(half_reg);
    b = longint'(row) - longint'(center_reg) - longint'(half_reg);
    d = tanh_at(a * recip) - tanh_at(b * recip);
    if (d < 0) d = 0;
    w = (d * 255) / 131072;
    if (w > 255) w = 255;
    res.b = mix(p.orig_b, p.blur_b, w);
    res.g = mix(p.orig_g, p.blur_g, w);
    res.r = mix(p.orig_r, p.blur_r, w);
    return res;
  endfunction

  function automatic void add_px(logic [ROW_W-1:0] row, pix_t p, bit typed, px_t want);
    stim_t s;
    s.kind  = STIM_PIX;
    s.idx   = '0;
    s.data  = '0;
    s.row   = row;
    s.pix   = p;
    s.typed = typed;
    s.want  = want;
    dir_tab.push_back(s);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    stim_t s;
    s.kind  = STIM_REG;
    s.idx   = idx;
    s.data  = data;
    s.row   = '0;
    s.pix   = '0;
    s.typed = 1'b0;
    s.want  = '0;
    dir_tab.push_back(s);
  endfunction

  task automatic idle_in(int n);
    in_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (idle_on && $urandom_range(0, 7) == 0) idle_in($urandom_range(1, 12));
  endtask

  task automatic push_pixel(logic [ROW_W-1:0] row, pix_t p, bit typed, px_t want);
    in_if.valid  <= 1'b1;
    in_if.row    <= row;
    in_if.orig_b <= p.orig_b;
    in_if.orig_g <= p.orig_g;
    in_if.orig_r <= p.orig_r;
    in_if.blur_b <= p.blur_b;
    in_if.blur_g <= p.blur_g;
    in_if.blur_r <= p.blur_r;
    do @(posedge clk); while (!in_if.ready);
    blend_q.push_back(typed ? want : predict_blend(row, p));
  endtask

  // drain the pipeline before touching registers
  task automatic settle();
    in_if.valid <= 1'b0;
    while (blend_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CENTER_ROW:  center_reg = data[CTR_W-1:0];
      CFG_HALF_HEIGHT: half_reg   = data[HALF_W-1:0];
      CFG_SOFTNESS:    soft_reg   = data[SOFT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] junk_above(int width);
    logic [CFG_W-1:0] j;
    j = CFG_W'($urandom);
    return j & ~((CFG_W'(1) << width) - 1'b1);
  endfunction

  task automatic set_band(int c, int h, int s);
    settle();
    write_reg(CFG_CENTER_ROW, CFG_W'(c));
    write_reg(CFG_HALF_HEIGHT, CFG_W'(h) | junk_above(HALF_W));
    write_reg(CFG_SOFTNESS, CFG_W'(s) | junk_above(SOFT_W));
  endtask

  function automatic bit field_ok(string name, logic [PIX_W-1:0] exp_v, logic [PIX_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 11);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_out
    px_t want;
    bit  ok;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (blend_q.size() == 0) begin
        $error("result beat with no pixel pending: b=%0d g=%0d r=%0d",
               out_if.out_b, out_if.out_g, out_if.out_r);
        errors++;
      end else begin
        want = blend_q.pop_front();
        ok = field_ok("out_b", want.b, out_if.out_b);
        ok = field_ok("out_g", want.g, out_if.out_g) && ok;
        ok = field_ok("out_r", want.r, out_if.out_r) && ok;
        if (!ok) errors++;
      end
    end
  end

  initial begin : stim
    longint unsigned p;
    longint unsigned num;
    longint unsigned den;
    int   c;
    int   h;
    int   s;
    int   spread;
    int   r;
    pix_t px;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    in_if.valid  = 1'b0;
    in_if.row    = '0;
    in_if.orig_b = '0;
    in_if.orig_g = '0;
    in_if.orig_r = '0;
    in_if.blur_b = '0;
    in_if.blur_g = '0;
    in_if.blur_r = '0;
    out_if.ready = 1'b0;
    errors       = 0;
    idle_on      = 1'b1;
    center_reg   = '0;
    half_reg     = '0;
    soft_reg     = 7'd7;

    p = 64'd16777216;
    for (int k = 0; k < TANH_ENTRIES; k++) begin
      num = (p - 64'd16777216) << 16;
      den = p + 64'd16777216;
      tanh_lut[k] = longint'((num + den / 2) / den);
      p = (p * 64'd17309782 + 64'd8388608) >> 24;
    end

    // out of reset the weight is zero: result is the blurred pixel
    add_px(12'd0,    48'hFFFFFF_000000, 1'b1, 24'h000000);
    add_px(12'd4095, 48'h000000_FFFFFF, 1'b1, 24'hFFFFFF);
    add_px(12'd2048, 48'h0C2238_C86432, 1'b1, 24'hC86432);
    add_px(12'd1,    48'h80FE01_7F01FE, 1'b1, 24'h7F01FE);
    // wide sharp band, hard edge: original pixel inside the band, blurred outside
    add_reg(CFG_CENTER_ROW, 12'd100);
    add_reg(CFG_HALF_HEIGHT, 12'h7FF);
    add_reg(CFG_SOFTNESS, 12'd1);
    add_px(12'd100,  48'hFF0080_00FF07, 1'b1, 24'hFF0080);
    add_px(12'd0,    48'h112233_010203, 1'b1, 24'h112233);
    add_px(12'd4095, 48'h112233_010203, 1'b1, 24'h010203);
    // zero softness acts as one
    add_reg(CFG_SOFTNESS, 12'd0);
    add_px(12'd100,  48'h5A5A5A_A5A5A5, 1'b1, 24'h5A5A5A);
    add_px(12'd2147, 48'hFFFFFF_FFFFFF, 1'b0, '0);
    add_px(12'd2146, 48'hFFFFFF_000000, 1'b0, '0);
    // zero band height: weight zero whatever the row
    add_reg(CFG_CENTER_ROW, 12'hFFF);
    add_reg(CFG_HALF_HEIGHT, 12'h800);
    add_reg(CFG_SOFTNESS, 12'hFFF);
    add_px(12'd4095, 48'h123456_654321, 1'b1, 24'h654321);
    add_px(12'd0,    48'hFEDCBA_ABCDEF, 1'b1, 24'hABCDEF);
    // unknown register index: drop the write
    add_reg(CFG_SPARE, 12'hFFF);
    add_px(12'd4000, 48'hFF00FF_00FF00, 1'b0, '0);
    add_reg(CFG_CENTER_ROW, 12'd2000);
    add_reg(CFG_HALF_HEIGHT, 12'd30);
    add_reg(CFG_SOFTNESS, 12'd101);
    add_px(12'd1970, 48'hFFFFFF_FFFFFF, 1'b0, '0);
    add_px(12'd1969, 48'hFFFFFF_000000, 1'b0, '0);
    add_px(12'd2000, 48'h000000_FFFFFF, 1'b0, '0);
    add_px(12'd2030, 48'h808080_7F7F7F, 1'b0, '0);
    add_px(12'd2031, 48'hFF0000_00FFFF, 1'b0, '0);
    add_px(12'd1900, 48'h000000_000000, 1'b0, '0);
    add_px(12'd2300, 48'h0102FE_FD0403, 1'b0, '0);
    add_reg(CFG_SOFTNESS, 12'd5);
    add_reg(CFG_HALF_HEIGHT, 12'd3);
    add_px(12'd1997, 48'hC0FFEE_123456, 1'b0, '0);
    add_px(12'd2003, 48'hFFFFFF_FFFFFF, 1'b0, '0);
    add_px(12'd2000, 48'hA0B0C0_0A0B0C, 1'b0, '0);
    add_px(12'd1990, 48'h7F8081_FEFF00, 1'b0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == STIM_REG) begin
        settle();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        maybe_gap();
        push_pixel(dir_tab[i].row, dir_tab[i].pix, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: set_band(0, 2047, 1);
        1: set_band(4095, 0, 0);
        2: set_band(2048, 2047, 127);
        default: begin
          c = $urandom_range(0, 4095);
          h = $urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(0, 2047);
          s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 101);
          set_band(c, h, s);
        end
      endcase
      idle_on = (ph < N_PHASES - 1) && ($urandom_range(0, 3) != 0);
      spread = 4 * ((soft_reg == 0) ? 1 : int'(soft_reg)) + 4;
      for (int n = 0; n < PHASE_PIX; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          r = $urandom_range(0, 4095);
        end else begin
          r = int'(center_reg) + ($urandom_range(0, 1) ? int'(half_reg) : -int'(half_reg));
          r = r + int'($urandom_range(0, 2 * spread)) - spread;
          if (r < 0) r = 0;
          if (r > 4095) r = 4095;
        end
        px = pix_t'(48'({$urandom, $urandom}));
        maybe_gap();
        push_pixel(ROW_W'(r), px, 1'b0, '0);
      end
    end

    settle();
    repeat (LAT + 8) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tsrb_pkg.sv
hw/rtl/tsrb_if.sv
hw/rtl/tilt_shift_row_blend.sv
dv/tilt_shift_row_blend_tb.sv
